// ===== src/gne_pkg.sv =====
// Shared types, codes, offset tables and helpers for the grid neighbour enumerator.
package gne_pkg;

    // Default limits for the top-level parameters.
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_MAX_RANGE   = 3;

    // Field and register widths.
    localparam int SIZE_W  = 9;
    localparam int ID_W    = 16;
    localparam int COORD_W = 8;
    localparam int TYPE_W  = 2;
    localparam int RANGE_W = 2;
    localparam int IDX_W   = 1;

    // Two-entry queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Reset value of both size registers.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_COLUMN_COUNT = 1'b0;
    localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 1'b1;

    // Request types.
    localparam logic [TYPE_W-1:0] REQ_FOUR   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_EIGHT  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_WINDOW = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_NONE   = 2'd3;

    // Neighbour offsets, two-bit two's complement.
    localparam logic [1:0] FOUR_DC [4]  = '{2'b00, 2'b00, 2'b01, 2'b11};
    localparam logic [1:0] FOUR_DR [4]  = '{2'b01, 2'b11, 2'b00, 2'b00};
    localparam logic [1:0] EIGHT_DC [8] = '{2'b11, 2'b00, 2'b01, 2'b11,
                                            2'b01, 2'b11, 2'b00, 2'b01};
    localparam logic [1:0] EIGHT_DR [8] = '{2'b11, 2'b11, 2'b11, 2'b00,
                                            2'b00, 2'b01, 2'b01, 2'b01};

    // One classified request waiting for enumeration.
    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [SIZE_W-1:0]  col;
        logic [SIZE_W-1:0]  row;
        logic [RANGE_W-1:0] range;
    } gne_item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_FLUSH
    } back_state_t;

    // A size of zero acts as one, a size above the limit acts as the limit.
    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int maxv);
        logic [SIZE_W-1:0] res;
        if (v == '0)
        begin
            res = SIZE_W'(1);
        end
        else if (int'(v) > maxv)
        begin
            res = SIZE_W'(maxv);
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== src/gne_front.sv =====
// Front part: accepts requests, splits the id into column and row, filters them.
module gne_front #(
    parameter int MAX_RANGE = gne_pkg::DEF_MAX_RANGE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [gne_pkg::TYPE_W-1:0]      req_type,
    input  logic [gne_pkg::ID_W-1:0]        cell_id,
    input  logic [gne_pkg::RANGE_W-1:0]     window_range,
    input  logic [gne_pkg::SIZE_W-1:0]      cols,
    input  logic [gne_pkg::SIZE_W-1:0]      rows,
    output logic                            push,
    output gne_pkg::gne_item_t              item,
    input  logic                            full
);
    import gne_pkg::*;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ID_W / 2 - 1);

    front_state_t        state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [RANGE_W-1:0]  range_reg;
    logic [ID_W-1:0]     quo_reg;
    logic [SIZE_W-1:0]   rem_reg;
    logic [SIZE_W:0]     step1, step2;
    logic                accept;
    logic                item_ok;
    logic [RANGE_W-1:0]  range_sat;

    // One restoring division step: returns the new remainder and the quotient bit.
    function automatic logic [SIZE_W:0] div_step(logic [SIZE_W-1:0] rem_in, logic din,
                                                 logic [SIZE_W-1:0] dv);
        logic [SIZE_W:0] trial;
        logic [SIZE_W:0] res;
        trial = {rem_in, din};
        if (trial >= {1'b0, dv})
        begin
            res = {SIZE_W'(trial - {1'b0, dv}), 1'b1};
        end
        else
        begin
            res = {trial[SIZE_W-1:0], 1'b0};
        end
        return res;
    endfunction

    assign accept = start && (state_reg == F_IDLE);
    assign busy   = (state_reg != F_IDLE);

    // Two quotient bits per cycle.
    assign step1 = div_step(rem_reg, quo_reg[ID_W-1], cols);
    assign step2 = div_step(step1[SIZE_W:1], quo_reg[ID_W-2], cols);

    // A window radius above the limit acts as the limit.
    assign range_sat = (int'(window_range) > MAX_RANGE) ? RANGE_W'(MAX_RANGE) : window_range;

    // The id lies inside the grid when its row is below the row count.
    assign item_ok = (quo_reg < {{(ID_W-SIZE_W){1'b0}}, rows}) && (type_reg != REQ_NONE) &&
                     !((type_reg == REQ_WINDOW) && (range_reg == '0));

    assign item.req_type = type_reg;
    assign item.col      = rem_reg;
    assign item.row      = quo_reg[SIZE_W-1:0];
    assign item.range    = range_reg;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Divider datapath.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            quo_reg   <= cell_id;
            rem_reg   <= '0;
            step_reg  <= '0;
            type_reg  <= req_type;
            range_reg <= range_sat;
        end
        else if (state_reg == F_DIV)
        begin
            quo_reg  <= {quo_reg[ID_W-3:0], step1[0], step2[0]};
            rem_reg  <= step2[SIZE_W:1];
            step_reg <= step_reg + 1'b1;
        end
    end

    // Next state and queue push.
    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!item_ok)
                begin
                    state_next = F_IDLE;
                end
                else if (!full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

// ===== src/gne_queue.sv =====
// Two-entry queue that decouples the front part from the back part.
module gne_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gne_pkg::gne_item_t push_item,
    input  logic               pop,
    output gne_pkg::gne_item_t head,
    output logic               empty,
    output logic               full
);
    import gne_pkg::*;

    gne_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/gne_back.sv =====
// Back part: walks the neighbour candidates of one request and emits those in the grid.
module gne_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gne_pkg::SIZE_W-1:0]    cols,
    input  logic [gne_pkg::SIZE_W-1:0]    rows,
    input  gne_pkg::gne_item_t            head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          result_valid,
    output logic [gne_pkg::ID_W-1:0]      neighbour_id,
    output logic [gne_pkg::COORD_W-1:0]   neighbour_col,
    output logic [gne_pkg::COORD_W-1:0]   neighbour_row,
    output logic                          last
);
    import gne_pkg::*;

    localparam int CAND_W = SIZE_W + 2;
    localparam int PROD_W = 2 * SIZE_W;

    back_state_t         state_reg, state_next;
    logic [TYPE_W-1:0]   typ_reg;
    logic [SIZE_W-1:0]   col_reg, row_reg;
    logic [2:0]          k_reg;
    logic [SIZE_W-1:0]   c_reg, r_reg;
    logic [SIZE_W-1:0]   cmax_reg, rmin_reg, rmax_reg;
    logic                hold_valid_reg;
    logic [SIZE_W-1:0]   hold_col_reg, hold_row_reg;
    logic                result_valid_reg;
    logic                last_reg;
    logic [ID_W-1:0]     id_reg;
    logic [COORD_W-1:0]  ncol_reg, nrow_reg;

    logic [1:0]          dc, dr;
    logic [CAND_W-1:0]   cand_c, cand_r;
    logic                in_grid, is_centre, cand_ok, cand_final;
    logic                emit, emit_last;
    logic [SIZE_W-1:0]   rg;
    logic [SIZE_W:0]     csum, rsum;
    logic [SIZE_W-1:0]   cmin_load, cmax_load, rmin_load, rmax_load;
    logic [PROD_W-1:0]   id_full;

    // Clipped window bounds of the request at the head of the queue.
    assign rg        = {{(SIZE_W-RANGE_W){1'b0}}, head.range};
    assign csum      = {1'b0, head.col} + {1'b0, rg};
    assign rsum      = {1'b0, head.row} + {1'b0, rg};
    assign cmin_load = (head.col >= rg) ? head.col - rg : '0;
    assign rmin_load = (head.row >= rg) ? head.row - rg : '0;
    assign cmax_load = (csum >= {1'b0, cols}) ? cols - 1'b1 : csum[SIZE_W-1:0];
    assign rmax_load = (rsum >= {1'b0, rows}) ? rows - 1'b1 : rsum[SIZE_W-1:0];

    // Offset of the current candidate for the fixed neighbourhoods.
    always_comb
    begin
        case (typ_reg)
            REQ_FOUR:
            begin
                dc = FOUR_DC[k_reg[1:0]];
                dr = FOUR_DR[k_reg[1:0]];
            end
            REQ_EIGHT:
            begin
                dc = EIGHT_DC[k_reg];
                dr = EIGHT_DR[k_reg];
            end
            default:
            begin
                dc = 2'b00;
                dr = 2'b00;
            end
        endcase
    end

    // Current candidate position, its bounds check and whether it ends the walk.
    always_comb
    begin
        if (typ_reg == REQ_WINDOW)
        begin
            cand_c = {2'b00, c_reg};
            cand_r = {2'b00, r_reg};
        end
        else
        begin
            cand_c = {2'b00, col_reg} + {{SIZE_W{dc[1]}}, dc};
            cand_r = {2'b00, row_reg} + {{SIZE_W{dr[1]}}, dr};
        end
        in_grid   = !cand_c[CAND_W-1] && (cand_c[SIZE_W:0] < {1'b0, cols}) &&
                    !cand_r[CAND_W-1] && (cand_r[SIZE_W:0] < {1'b0, rows});
        is_centre = (typ_reg == REQ_WINDOW) && (c_reg == col_reg) && (r_reg == row_reg);
        cand_ok   = in_grid && !is_centre;
        case (typ_reg)
            REQ_FOUR:   cand_final = (k_reg == 3'd3);
            REQ_EIGHT:  cand_final = (k_reg == 3'd7);
            REQ_WINDOW: cand_final = (c_reg == cmax_reg) && (r_reg == rmax_reg);
            default:    cand_final = 1'b1;
        endcase
    end

    // Next state; a held result goes out once the next one is known, or at the end.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                emit = cand_ok && hold_valid_reg;
                if (cand_final)
                begin
                    state_next = B_FLUSH;
                end
            end
            B_FLUSH:
            begin
                emit       = hold_valid_reg;
                emit_last  = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= emit;
            if (pop)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if ((state_reg == B_RUN) && cand_ok)
            begin
                hold_valid_reg <= 1'b1;
            end
        end
    end

    // Walk counters and the held candidate.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            typ_reg  <= head.req_type;
            col_reg  <= head.col;
            row_reg  <= head.row;
            k_reg    <= '0;
            cmax_reg <= cmax_load;
            rmin_reg <= rmin_load;
            rmax_reg <= rmax_load;
            c_reg    <= cmin_load;
            r_reg    <= rmin_load;
        end
        else if (state_reg == B_RUN)
        begin
            k_reg <= k_reg + 1'b1;
            if (r_reg == rmax_reg)
            begin
                r_reg <= rmin_reg;
                c_reg <= c_reg + 1'b1;
            end
            else
            begin
                r_reg <= r_reg + 1'b1;
            end
            if (cand_ok)
            begin
                hold_col_reg <= cand_c[SIZE_W-1:0];
                hold_row_reg <= cand_r[SIZE_W-1:0];
            end
        end
    end

    // Result register: row-major id of the held neighbour.
    assign id_full = PROD_W'(hold_row_reg) * PROD_W'(cols) + PROD_W'(hold_col_reg);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            id_reg   <= id_full[ID_W-1:0];
            ncol_reg <= hold_col_reg[COORD_W-1:0];
            nrow_reg <= hold_row_reg[COORD_W-1:0];
            last_reg <= emit_last;
        end
    end

    assign result_valid  = result_valid_reg;
    assign neighbour_id  = id_reg;
    assign neighbour_col = ncol_reg;
    assign neighbour_row = nrow_reg;
    assign last          = result_valid_reg && last_reg;

endmodule

// ===== src/grid_neighbour_enumerator.sv =====
// Top level of the grid neighbour enumerator: size registers, front, queue and back.
//
//  Channel   Handshake                    Payload
//  -------   ---------------------------  ------------------------------------------
//  request   start & !busy                req_type, cell_id, window_range
//  result    result_valid (one cycle)     neighbour_id, neighbour_col, neighbour_row, last
//  config    cfg_we                       cfg_index, cfg_data
//
// After the request transfer the front runs the two-bit-per-cycle divider that splits the
// id into column and row, then hands the request to the two-entry queue or drops it if it
// fails the filter; busy stays high all the while, so the front holds one request at a time.
// The back loads a request, tests one candidate per cycle (4, 8 or up to 49) and closes it
// in a flush state; each result waits until the next is found so that last can be set.
// Reset sets both sizes to 256 and empties the queue; the front stalls only on a full queue.
module grid_neighbour_enumerator #(
    parameter int MAX_COLUMNS = gne_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gne_pkg::DEF_MAX_ROWS,
    parameter int MAX_RANGE   = gne_pkg::DEF_MAX_RANGE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gne_pkg::TYPE_W-1:0]    req_type,
    input  logic [gne_pkg::ID_W-1:0]      cell_id,
    input  logic [gne_pkg::RANGE_W-1:0]   window_range,
    output logic                          result_valid,
    output logic [gne_pkg::ID_W-1:0]      neighbour_id,
    output logic [gne_pkg::COORD_W-1:0]   neighbour_col,
    output logic [gne_pkg::COORD_W-1:0]   neighbour_row,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [gne_pkg::IDX_W-1:0]     cfg_index,
    input  logic [gne_pkg::SIZE_W-1:0]    cfg_data
);
    import gne_pkg::*;

    logic [SIZE_W-1:0] column_count_reg;
    logic [SIZE_W-1:0] row_count_reg;
    logic [SIZE_W-1:0] cols, rows;
    logic              q_push, q_pop, q_empty, q_full;
    gne_item_t         q_in, q_head;

    // Size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= SIZE_RESET;
            row_count_reg    <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective grid size.
    assign cols = clamp_size(column_count_reg, MAX_COLUMNS);
    assign rows = clamp_size(row_count_reg, MAX_ROWS);

    gne_front #(
        .MAX_RANGE (MAX_RANGE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .cell_id      (cell_id),
        .window_range (window_range),
        .cols         (cols),
        .rows         (rows),
        .push         (q_push),
        .item         (q_in),
        .full         (q_full)
    );

    gne_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    gne_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cols          (cols),
        .rows          (rows),
        .head          (q_head),
        .empty         (q_empty),
        .pop           (q_pop),
        .result_valid  (result_valid),
        .neighbour_id  (neighbour_id),
        .neighbour_col (neighbour_col),
        .neighbour_row (neighbour_row),
        .last          (last)
    );

`ifndef ASSERT_OFF
    // The front never pushes into a full queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    // The back never pops an empty queue.
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // An accepted request keeps the front busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("front not busy after accepting a request");

    // Every emitted column lies inside the grid.
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, neighbour_col} < cols))
        else $error("neighbour column outside the grid");
`endif

endmodule
